/* hdl/mht_pkg.sv */
package mht_pkg;

    // Field widths fixed by the interface.
    localparam int KEY_W   = 31;
    localparam int CAP_W   = 9;
    localparam int SLOT_W  = 8;
    localparam int ADDR_W  = 3;
    localparam int DATA_W  = 32;

    // Reset value of the capacity register.
    localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

    // Register index of the capacity register.
    localparam logic REG_CAPACITY = 1'b0;

    // Depth of the request queue between front and back.
    localparam int QUEUE_DEPTH = 2;

    // Request kinds as they arrive on the input channel.
    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_REMOVE = 1'b1;

    // Result codes.
    typedef enum logic [1:0] {
        STAT_INSERTED  = 2'd0,
        STAT_REMOVED   = 2'd1,
        STAT_NOT_FOUND = 2'd2
    } status_t;

    // Operation class chosen by the front.
    typedef enum logic [1:0] {
        OP_INS_DIRECT = 2'd0,
        OP_INS_MOD    = 2'd1,
        OP_REMOVE     = 2'd2
    } op_t;

    // One queued request.
    typedef struct packed {
        op_t              op;
        logic [KEY_W-1:0] key;
    } entry_t;

    // Back-end sequencer states.
    typedef enum logic [2:0] {
        ST_CLEAR  = 3'd0,
        ST_IDLE   = 3'd1,
        ST_MOD    = 3'd2,
        ST_SCAN   = 3'd3,
        ST_RESULT = 3'd4
    } state_t;

    // Status that the back end reports to the rest of the block.
    typedef struct packed {
        logic   clearing;
        state_t state;
    } back_status_t;

endpackage

/* hdl/mht_front.sv */
module mht_front (
    input  logic                        valid,
    input  logic                        kind,
    input  logic [mht_pkg::KEY_W-1:0]   key,
    input  logic [mht_pkg::CAP_W-1:0]   eff_cap,
    input  logic                        clearing,
    input  logic                        q_full,
    output logic                        stall,
    output logic                        push,
    output mht_pkg::entry_t             entry
);

    // Hold requests off while the table is being cleared or the queue is full.
    assign stall = clearing | q_full;
    assign push  = valid & ~stall;

    // Classify the request. An insert whose key is already below the capacity
    // hashes to itself, so it needs no modulo pass in the back end.
    always_comb
    begin
        entry.key = key;
        if (kind == mht_pkg::KIND_REMOVE)
        begin
            entry.op = mht_pkg::OP_REMOVE;
        end
        else if (key < mht_pkg::KEY_W'(eff_cap))
        begin
            entry.op = mht_pkg::OP_INS_DIRECT;
        end
        else
        begin
            entry.op = mht_pkg::OP_INS_MOD;
        end
    end

endmodule

/* hdl/mht_fifo.sv */
module mht_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  mht_pkg::entry_t push_data,
    input  logic            pop,
    output logic            full,
    output logic            not_empty,
    output mht_pkg::entry_t head
);

    localparam int PTR_W = $clog2(mht_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(mht_pkg::QUEUE_DEPTH + 1);

    mht_pkg::entry_t  store_reg [mht_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full      = (count_reg == CNT_W'(mht_pkg::QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = store_reg[rd_ptr_reg];

    // Pointer and fill-level update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* hdl/mht_mod.sv */
module mht_mod (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [mht_pkg::KEY_W-1:0]   dividend,
    input  logic [mht_pkg::CAP_W-1:0]   divisor,
    output logic                        done,
    output logic [mht_pkg::CAP_W-1:0]   remainder
);

    localparam int KEY_W  = mht_pkg::KEY_W;
    localparam int CAP_W  = mht_pkg::CAP_W;
    localparam int STEP_W = $clog2(KEY_W);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [KEY_W-1:0]  shift_reg;
    logic [CAP_W-1:0]  rem_reg;
    logic [CAP_W:0]    trial;
    logic [CAP_W:0]    rem_step;

    // One restoring step: bring in the next dividend bit and subtract the
    // divisor when it fits. The partial remainder stays below the divisor.
    always_comb
    begin
        trial = {rem_reg, shift_reg[KEY_W-1]};
        if (trial >= {1'b0, divisor})
        begin
            rem_step = trial - {1'b0, divisor};
        end
        else
        begin
            rem_step = trial;
        end
    end

    // Step control: one dividend bit per cycle, most significant first.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= STEP_W'(KEY_W - 1);
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg - STEP_W'(1);
                if (step_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath of the divider.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            shift_reg <= dividend;
            rem_reg   <= '0;
        end
        else if (busy_reg)
        begin
            shift_reg <= {shift_reg[KEY_W-2:0], 1'b0};
            rem_reg   <= CAP_W'(rem_step);
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

/* hdl/mht_back.sv */
module mht_back #(
    parameter int TABLE_DEPTH = 256
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [mht_pkg::CAP_W-1:0]   eff_cap,
    input  logic                        q_valid,
    input  mht_pkg::entry_t             q_head,
    output logic                        q_pop,
    output logic                        mod_start,
    output logic [mht_pkg::KEY_W-1:0]   mod_dividend,
    input  logic                        mod_done,
    input  logic [mht_pkg::CAP_W-1:0]   mod_rem,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [1:0]                  out_status,
    output logic [mht_pkg::SLOT_W-1:0]  out_slot,
    output mht_pkg::back_status_t       bstat
);

    localparam int IDX_W  = $clog2(TABLE_DEPTH);
    localparam int KEY_W  = mht_pkg::KEY_W;
    localparam int CAP_W  = mht_pkg::CAP_W;
    localparam int SLOT_W = mht_pkg::SLOT_W;

    // Slot store and its registered read port.
    logic [KEY_W-1:0]     mem [TABLE_DEPTH];
    logic [KEY_W-1:0]     rdata_reg;
    logic                 mem_we;
    logic [IDX_W-1:0]     mem_waddr;
    logic [KEY_W-1:0]     mem_wdata;
    logic [IDX_W-1:0]     mem_raddr;

    mht_pkg::state_t      state_reg;
    mht_pkg::state_t      state_next;
    mht_pkg::entry_t      item_reg;
    logic [IDX_W-1:0]     clr_cnt_reg;
    logic [CAP_W-1:0]     cnt_reg;
    logic [CAP_W-1:0]     cnt_next;
    logic                 rd_vld_reg;
    logic                 rd_vld_next;
    logic [CAP_W-1:0]     rd_idx_reg;
    mht_pkg::status_t     res_status_reg;
    mht_pkg::status_t     res_status_next;
    logic [IDX_W-1:0]     res_idx_reg;
    logic [IDX_W-1:0]     res_idx_next;
    logic                 res_load;
    logic                 out_valid_reg;
    logic [1:0]           out_status_reg;
    logic [SLOT_W-1:0]    out_slot_reg;
    logic                 out_free;
    logic                 out_load;
    logic                 clr_done;
    logic                 issue;
    logic                 hit;
    logic                 last;

    // Scan and handshake conditions.
    assign out_free = ~out_valid_reg | ~out_stall;
    assign clr_done = (clr_cnt_reg == IDX_W'(TABLE_DEPTH - 1));
    assign issue    = (cnt_reg < eff_cap);
    assign hit      = rd_vld_reg && (rdata_reg == item_reg.key);
    assign last     = rd_vld_reg && (rd_idx_reg == (eff_cap - CAP_W'(1)));

    // Next-state logic of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mht_pkg::ST_CLEAR:
            begin
                if (clr_done)
                begin
                    state_next = mht_pkg::ST_IDLE;
                end
            end
            mht_pkg::ST_IDLE:
            begin
                if (q_valid)
                begin
                    unique case (q_head.op)
                        mht_pkg::OP_INS_DIRECT: state_next = mht_pkg::ST_RESULT;
                        mht_pkg::OP_INS_MOD:    state_next = mht_pkg::ST_MOD;
                        mht_pkg::OP_REMOVE:     state_next = mht_pkg::ST_SCAN;
                        default:                state_next = mht_pkg::ST_IDLE;
                    endcase
                end
            end
            mht_pkg::ST_MOD:
            begin
                if (mod_done)
                begin
                    state_next = mht_pkg::ST_RESULT;
                end
            end
            mht_pkg::ST_SCAN:
            begin
                if (hit || last)
                begin
                    state_next = mht_pkg::ST_RESULT;
                end
            end
            mht_pkg::ST_RESULT:
            begin
                if (out_free)
                begin
                    state_next = mht_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mht_pkg::ST_IDLE;
            end
        endcase
    end

    // Output and datapath control of the sequencer.
    always_comb
    begin
        q_pop           = 1'b0;
        mod_start       = 1'b0;
        mem_we          = 1'b0;
        mem_waddr       = '0;
        mem_wdata       = '0;
        res_load        = 1'b0;
        res_status_next = mht_pkg::STAT_INSERTED;
        res_idx_next    = '0;
        cnt_next        = cnt_reg;
        rd_vld_next     = 1'b0;
        out_load        = 1'b0;
        unique case (state_reg)
            mht_pkg::ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_cnt_reg;
            end
            mht_pkg::ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    unique case (q_head.op)
                        mht_pkg::OP_INS_DIRECT:
                        begin
                            mem_we          = 1'b1;
                            mem_waddr       = IDX_W'(q_head.key);
                            mem_wdata       = q_head.key;
                            res_load        = 1'b1;
                            res_status_next = mht_pkg::STAT_INSERTED;
                            res_idx_next    = IDX_W'(q_head.key);
                        end
                        mht_pkg::OP_INS_MOD:
                        begin
                            mod_start = 1'b1;
                        end
                        mht_pkg::OP_REMOVE:
                        begin
                            cnt_next = '0;
                        end
                        default:
                        begin
                            q_pop = 1'b1;
                        end
                    endcase
                end
            end
            mht_pkg::ST_MOD:
            begin
                if (mod_done)
                begin
                    mem_we          = 1'b1;
                    mem_waddr       = IDX_W'(mod_rem);
                    mem_wdata       = item_reg.key;
                    res_load        = 1'b1;
                    res_status_next = mht_pkg::STAT_INSERTED;
                    res_idx_next    = IDX_W'(mod_rem);
                end
            end
            mht_pkg::ST_SCAN:
            begin
                if (hit)
                begin
                    mem_we          = 1'b1;
                    mem_waddr       = IDX_W'(rd_idx_reg);
                    res_load        = 1'b1;
                    res_status_next = mht_pkg::STAT_REMOVED;
                    res_idx_next    = IDX_W'(rd_idx_reg);
                end
                else if (last)
                begin
                    res_load        = 1'b1;
                    res_status_next = mht_pkg::STAT_NOT_FOUND;
                end
                else if (issue)
                begin
                    cnt_next    = cnt_reg + CAP_W'(1);
                    rd_vld_next = 1'b1;
                end
            end
            mht_pkg::ST_RESULT:
            begin
                out_load = out_free;
            end
            default:
            begin
                out_load = 1'b0;
            end
        endcase
    end

    assign mod_dividend = q_head.key;
    assign mem_raddr    = IDX_W'(cnt_reg);

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mht_pkg::ST_CLEAR;
            clr_cnt_reg   <= '0;
            cnt_reg       <= '0;
            rd_vld_reg    <= 1'b0;
            rd_idx_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            rd_vld_reg <= rd_vld_next;
            rd_idx_reg <= cnt_reg;
            if (state_reg == mht_pkg::ST_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + IDX_W'(1);
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers: current request, pending result and output.
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            item_reg <= q_head;
        end
        if (res_load)
        begin
            res_status_reg <= res_status_next;
            res_idx_reg    <= res_idx_next;
        end
        if (out_load)
        begin
            out_status_reg <= res_status_reg;
            out_slot_reg   <= SLOT_W'(res_idx_reg);
        end
    end

    // Slot memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[mem_raddr];
    end

    assign out_valid      = out_valid_reg;
    assign out_status     = out_status_reg;
    assign out_slot       = out_slot_reg;
    assign bstat.clearing = (state_reg == mht_pkg::ST_CLEAR);
    assign bstat.state    = state_reg;

endmodule

/* hdl/modulo_hash_table_top.sv */
// Flow, from the request being taken by an idle block to its result being valid: an insert
// whose key is below the capacity writes its slot at once, any other insert first waits for
// the 31-step modulo divider, and a remove scans the slots from zero up to the one that
// matches, or up to capacity-1 when nothing matches.
// The back end takes one request at a time, held by the slot scan or the divider.
// Reset: capacity returns to 256 and a clearing pass empties every slot, during which no
// request is taken; configuration writes are taken throughout.
module modulo_hash_table_top #(
    parameter int TABLE_DEPTH = 256
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            kind,
    input  logic [mht_pkg::KEY_W-1:0]       key,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [1:0]                      status,
    output logic [mht_pkg::SLOT_W-1:0]      slot,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [mht_pkg::ADDR_W-1:0]      paddr,
    input  logic [mht_pkg::DATA_W-1:0]      pwdata,
    output logic [mht_pkg::DATA_W-1:0]      prdata,
    output logic                            pready
);

    localparam int CAP_W = mht_pkg::CAP_W;

    logic [CAP_W-1:0]       cap_reg;
    logic [CAP_W-1:0]       eff_cap;
    logic                   reg_index;
    logic                   cfg_write;
    logic                   q_full;
    logic                   q_valid;
    logic                   q_push;
    logic                   q_pop;
    mht_pkg::entry_t        push_entry;
    mht_pkg::entry_t        q_head;
    logic                   mod_start;
    logic [mht_pkg::KEY_W-1:0] mod_dividend;
    logic                   mod_done;
    logic [CAP_W-1:0]       mod_rem;
    mht_pkg::back_status_t  bstat;

    // Configuration port: capacity is the only register.
    assign pready    = 1'b1;
    assign reg_index = paddr[mht_pkg::ADDR_W-1];
    assign cfg_write = psel & penable & pwrite & pready;
    assign prdata    = (reg_index == mht_pkg::REG_CAPACITY)
                       ? mht_pkg::DATA_W'(cap_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= mht_pkg::CAP_RESET;
        end
        else if (cfg_write && (reg_index == mht_pkg::REG_CAPACITY))
        begin
            cap_reg <= pwdata[CAP_W-1:0];
        end
    end

    // Capacity in use: zero counts as one and the table depth is the ceiling.
    always_comb
    begin
        if (cap_reg == '0)
        begin
            eff_cap = CAP_W'(1);
        end
        else if (32'(cap_reg) > TABLE_DEPTH)
        begin
            eff_cap = CAP_W'(TABLE_DEPTH);
        end
        else
        begin
            eff_cap = cap_reg;
        end
    end

    mht_front u_front (
        .valid    (in_valid),
        .kind     (kind),
        .key      (key),
        .eff_cap  (eff_cap),
        .clearing (bstat.clearing),
        .q_full   (q_full),
        .stall    (in_stall),
        .push     (q_push),
        .entry    (push_entry)
    );

    mht_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (push_entry),
        .pop       (q_pop),
        .full      (q_full),
        .not_empty (q_valid),
        .head      (q_head)
    );

    mht_mod u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (mod_start),
        .dividend  (mod_dividend),
        .divisor   (eff_cap),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    mht_back #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .eff_cap      (eff_cap),
        .q_valid      (q_valid),
        .q_head       (q_head),
        .q_pop        (q_pop),
        .mod_start    (mod_start),
        .mod_dividend (mod_dividend),
        .mod_done     (mod_done),
        .mod_rem      (mod_rem),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_status   (status),
        .out_slot     (slot),
        .bstat        (bstat)
    );

    // While the table is being cleared no request is taken and no result leaves.
    assert property (@(posedge clk) disable iff (!rst_n)
        bstat.clearing |-> (in_stall && !out_valid))
        else $error("request or result during the clearing pass");

    // A request that finds nothing reports slot zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == mht_pkg::STAT_NOT_FOUND)) |-> (slot == '0))
        else $error("not-found result with a non-zero slot");

    // The divider finishes only while the sequencer waits for it.
    assert property (@(posedge clk) disable iff (!rst_n)
        mod_done |-> (bstat.state == mht_pkg::ST_MOD))
        else $error("modulo result outside the modulo wait");

endmodule

/* tb/tb_top.sv */
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          DEPTH       = 256;
    localparam int          HOLD_CYCLES = 400;
    localparam longint      LIMIT_NS    = 40_000_000;
    localparam logic [mht_pkg::ADDR_W-1:0] CAP_ADDR =
        mht_pkg::ADDR_W'(4 * int'(mht_pkg::REG_CAPACITY));

    // One expected result: status code and slot index.
    typedef struct packed {
        mht_pkg::status_t           code;
        logic [mht_pkg::SLOT_W-1:0] index;
    } outcome_t;

    logic                          clk       = 1'b0;
    logic                          rst_n     = 1'b0;
    logic                          in_valid  = 1'b0;
    logic                          in_stall;
    logic                          kind      = mht_pkg::KIND_INSERT;
    logic [mht_pkg::KEY_W-1:0]     key       = '0;
    logic                          out_valid;
    logic                          out_stall = 1'b0;
    logic [1:0]                    status;
    logic [mht_pkg::SLOT_W-1:0]    slot;
    logic                          psel      = 1'b0;
    logic                          penable   = 1'b0;
    logic                          pwrite    = 1'b0;
    logic [mht_pkg::ADDR_W-1:0]    paddr     = '0;
    logic [mht_pkg::DATA_W-1:0]    pwdata    = '0;
    logic [mht_pkg::DATA_W-1:0]    prdata;
    logic                          pready;

    // Shadow of the table contents and of the capacity register.
    logic [mht_pkg::KEY_W-1:0]     slot_keys [DEPTH];
    logic [mht_pkg::CAP_W-1:0]     cap_reg = mht_pkg::CAP_RESET;

    outcome_t                      pending_outcomes [$];
    logic [mht_pkg::KEY_W-1:0]     recent_keys [$];
    int unsigned                   error_count = 0;
    bit                            no_gaps     = 1'b0;
    bit                            hold_pending = 1'b0;
    bit                            hold_done    = 1'b0;

    modulo_hash_table_top #(
        .TABLE_DEPTH(DEPTH)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .kind     (kind),
        .key      (key),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .status   (status),
        .slot     (slot),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Free-running clock, 10 ns period.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Number of slots actually in use: zero counts as one, large values saturate.
    function automatic int unsigned live_span();
        if (cap_reg == '0)
            return 1;
        if (cap_reg > DEPTH)
            return DEPTH;
        return cap_reg;
    endfunction

    // Apply one request to the shadow table and return the result it gives.
    function automatic outcome_t apply_request(input logic op,
                                               input logic [mht_pkg::KEY_W-1:0] k);
        int unsigned span;
        int unsigned i;
        outcome_t    res;
        span      = live_span();
        res.code  = mht_pkg::STAT_NOT_FOUND;
        res.index = '0;
        if (op == mht_pkg::KIND_INSERT)
        begin
            slot_keys[k % span] = k;
            res.code  = mht_pkg::STAT_INSERTED;
            res.index = mht_pkg::SLOT_W'(k % span);
        end
        else
        begin
            for (i = 0; i < span; i++)
            begin
                if (slot_keys[i] == k)
                begin
                    slot_keys[i] = '0;
                    res.code  = mht_pkg::STAT_REMOVED;
                    res.index = mht_pkg::SLOT_W'(i);
                    break;
                end
            end
        end
        return res;
    endfunction

    // Idle length between requests: mostly none, sometimes short, rarely long.
    function automatic int unsigned gap_cycles();
        int unsigned r;
        r = $urandom_range(99, 0);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(3, 1);
        return $urandom_range(60, 10);
    endfunction

    // Offer one request and wait until it is taken; the expected result is queued then.
    task automatic send_request(input logic op, input logic [mht_pkg::KEY_W-1:0] k);
        int unsigned gap;
        gap = no_gaps ? 0 : gap_cycles();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        kind     <= op;
        key      <= k;
        do
            @(posedge clk);
        while (in_stall);
        pending_outcomes.push_back(apply_request(op, k));
    endtask

    // Lower valid and wait until every outstanding result has been seen.
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_outcomes.size() != 0)
            @(posedge clk);
    endtask

    // Write the capacity register: setup cycle, access cycle, then the bus returns to idle.
    task automatic write_capacity(input logic [mht_pkg::DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CAP_ADDR;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        cap_reg = value[mht_pkg::CAP_W-1:0];
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Behaviour at the reset capacity: direct and wrapped inserts, overwrites, key zero.
    task automatic test_reset_state();
        send_request(mht_pkg::KIND_INSERT, '0);
        send_request(mht_pkg::KIND_INSERT, 31'd5);
        send_request(mht_pkg::KIND_INSERT, 31'd255);
        send_request(mht_pkg::KIND_INSERT, 31'h7FFF_FFFF);
        send_request(mht_pkg::KIND_INSERT, 31'd261);
        send_request(mht_pkg::KIND_REMOVE, 31'd5);
        send_request(mht_pkg::KIND_REMOVE, 31'd261);
        send_request(mht_pkg::KIND_REMOVE, 31'h7FFF_FFFF);
        send_request(mht_pkg::KIND_REMOVE, '0);
        send_request(mht_pkg::KIND_REMOVE, 31'd255);
        wait_idle();
    endtask

    // Capacity at zero, one, above the table depth, and shrunk over occupied slots.
    task automatic test_capacity_limits();
        write_capacity(32'd0);
        send_request(mht_pkg::KIND_INSERT, 31'd7);
        send_request(mht_pkg::KIND_REMOVE, '0);
        send_request(mht_pkg::KIND_REMOVE, 31'd7);
        wait_idle();
        write_capacity(32'd511);
        send_request(mht_pkg::KIND_INSERT, 31'd300);
        send_request(mht_pkg::KIND_REMOVE, 31'd300);
        wait_idle();
        write_capacity(32'd300);
        send_request(mht_pkg::KIND_INSERT, 31'h4000_0000);
        wait_idle();
        write_capacity(32'd1);
        send_request(mht_pkg::KIND_INSERT, 31'h7FFF_FFFF);
        wait_idle();
        write_capacity(32'd256);
        send_request(mht_pkg::KIND_INSERT, 31'd200);
        wait_idle();
        // The key in slot 200 stays put but is out of reach while the capacity is 100.
        write_capacity(32'd100);
        send_request(mht_pkg::KIND_REMOVE, 31'd200);
        send_request(mht_pkg::KIND_INSERT, 31'd150);
        wait_idle();
        write_capacity(32'd256);
        send_request(mht_pkg::KIND_REMOVE, 31'd200);
        send_request(mht_pkg::KIND_REMOVE, 31'd150);
        wait_idle();
    endtask

    // Hold the output off for a long stretch while requests keep coming, so the input stalls.
    task automatic test_backpressure();
        int unsigned n;
        write_capacity(32'd16);
        no_gaps      = 1'b1;
        hold_pending = 1'b1;
        for (n = 0; n < 16; n++)
            send_request((n >= 10) ? mht_pkg::KIND_REMOVE : mht_pkg::KIND_INSERT,
                         mht_pkg::KEY_W'(n * 17 + 3));
        wait (hold_done);
        no_gaps = 1'b0;
        wait_idle();
    endtask

    // Random phases over several capacities; most removes aim at keys inserted earlier.
    task automatic test_random_traffic();
        int unsigned caps [8] = '{97, 1, 2, 256, 0, 511, 0, 31};
        int unsigned phase;
        int unsigned n;
        int unsigned r;
        int unsigned r2;
        int unsigned span;
        logic        op;
        logic [mht_pkg::KEY_W-1:0] k;
        for (phase = 0; phase < 8; phase++)
        begin
            if (phase == 6)
                write_capacity($urandom_range(255, 3));
            else
                write_capacity(caps[phase]);
            no_gaps = ($urandom_range(3, 0) == 0);
            span    = live_span();
            for (n = 0; n < 150; n++)
            begin
                r = $urandom_range(99, 0);
                if (r < 55)
                begin
                    op = mht_pkg::KIND_INSERT;
                    r2 = $urandom_range(9, 0);
                    if (r2 < 4)
                        k = mht_pkg::KEY_W'($urandom_range(span - 1, 0));
                    else if (r2 < 7)
                        k = mht_pkg::KEY_W'($urandom);
                    else if (r2 < 9)
                        k = mht_pkg::KEY_W'($urandom_range(span - 1, 0)
                                            + span * $urandom_range(1000, 1));
                    else
                        k = '0;
                    recent_keys.push_back(k);
                    if (recent_keys.size() > 48)
                        void'(recent_keys.pop_front());
                end
                else
                begin
                    op = mht_pkg::KIND_REMOVE;
                    if (r < 82 && recent_keys.size() > 0)
                        k = recent_keys[$urandom_range(recent_keys.size() - 1, 0)];
                    else if (r < 88)
                        k = '0;
                    else
                        k = mht_pkg::KEY_W'($urandom);
                end
                send_request(op, k);
            end
            wait_idle();
        end
        no_gaps = 1'b0;
    endtask

    // Receiver: random stall runs, long free runs, and one counted hold-off on demand.
    initial
    begin : receiver
        int unsigned run_left;
        bit          stalling;
        run_left = 0;
        stalling = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_pending && !hold_done)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES - 1) @(posedge clk);
                hold_done = 1'b1;
                run_left  = 0;
            end
            else
            begin
                if (run_left == 0)
                begin
                    stalling = ($urandom_range(99, 0) < 30);
                    if (stalling)
                        run_left = 1 + gap_cycles();
                    else if ($urandom_range(9, 0) == 0)
                        run_left = $urandom_range(250, 50);
                    else
                        run_left = $urandom_range(8, 1);
                end
                run_left--;
                out_stall <= stalling;
            end
        end
    end

    // Compare every result taken from the block with the oldest expected one.
    always @(posedge clk)
    begin
        outcome_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_outcomes.size() == 0)
            begin
                $error("result with no request outstanding: status %0d, slot %0d", status, slot);
                error_count++;
            end
            else
            begin
                want = pending_outcomes.pop_front();
                if (status !== want.code)
                begin
                    $error("status: expected %0d, actual %0d", want.code, status);
                    error_count++;
                end
                if (slot !== want.index)
                begin
                    $error("slot: expected %0d, actual %0d", want.index, slot);
                    error_count++;
                end
            end
        end
    end

    // Run-time guard.
    initial
    begin
        #(LIMIT_NS);
        $display("[modulo_hash_table_top] ERROR");
        $finish;
    end

    // Test sequence.
    initial
    begin
        foreach (slot_keys[i])
            slot_keys[i] = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        test_reset_state();
        test_capacity_limits();
        test_backpressure();
        test_random_traffic();
        repeat (DEPTH + 8) @(posedge clk);
        if (error_count == 0 && pending_outcomes.size() == 0)
            $display("[modulo_hash_table_top] OK");
        else
            $display("[modulo_hash_table_top] ERROR");
        $finish;
    end

endmodule
